// ----- design/ils_pkg.sv -----
// Shared types, codes and sizes for the indexed list store.
package ils_pkg;

  localparam int unsigned DEFAULT_CAPACITY = 16;
  localparam int unsigned POS_W = 7;

  typedef enum logic [2:0] {
    OP_READ = 3'd0,
    OP_HEAD = 3'd1,
    OP_TAIL = 3'd2,
    OP_AT   = 3'd3,
    OP_DEL  = 3'd4
  } opcode_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic [2:0]         opcode;
    logic signed [7:0]  index;
    logic signed [31:0] value;
  } item_t;

  typedef struct packed {
    logic signed [31:0] read_value;
    logic [1:0]         status;
    logic [4:0]         length;
  } result_t;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic               rd;
    logic               ins;
    logic               del;
    logic [POS_W-1:0]   pos;
    logic signed [31:0] value;
  } ctrl_t;

endpackage

// ----- design/ils_cell.sv -----
// One storage cell of the list chain: holds one entry and shifts with its neighbours.
module ils_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic               clk,
  input  ils_pkg::ctrl_t     ctrl,
  input  logic signed [31:0] left,
  input  logic signed [31:0] right,
  output logic signed [31:0] data,
  output logic signed [31:0] tap
);

  localparam logic [ils_pkg::POS_W-1:0] MY_POS = ils_pkg::POS_W'(IDX);

  always_ff @(posedge clk) begin
    if (ctrl.ins) begin
      if (MY_POS > ctrl.pos) begin
        data <= left;
      end else if (MY_POS == ctrl.pos) begin
        data <= ctrl.value;
      end
    end else if (ctrl.del) begin
      if (MY_POS >= ctrl.pos) begin
        data <= right;
      end
    end
  end

  // Only the addressed cell drives its word onto the read bus.
  assign tap = (ctrl.rd && (MY_POS == ctrl.pos)) ? data : '0;

endmodule

// ----- design/ils_decode.sv -----
// Operation decode: range and full checks, cell command and next length.
module ils_decode #(
  parameter int unsigned CAPACITY = ils_pkg::DEFAULT_CAPACITY,
  parameter int unsigned CW       = $clog2(CAPACITY + 1)
) (
  input  logic              go,
  input  ils_pkg::item_t    item,
  input  logic [CW-1:0]     count,
  output ils_pkg::ctrl_t    ctrl,
  output ils_pkg::status_t  status,
  output logic              read_miss,
  output logic [CW-1:0]     count_next
);

  logic [7:0] cnt8;
  logic [7:0] idx8;
  logic [7:0] at8;
  logic       neg;
  logic       in_rng;
  logic       full;

  always_comb begin
    cnt8   = 8'(count);
    neg    = item.index[7];
    idx8   = {1'b0, item.index[6:0]};
    at8    = neg ? 8'd0 : idx8;
    in_rng = !neg && (idx8 < cnt8);
    full   = (cnt8 == 8'(CAPACITY));

    ctrl       = '0;
    ctrl.value = item.value;
    status     = ils_pkg::ST_DONE;
    read_miss  = 1'b0;
    count_next = count;

    case (item.opcode)
      ils_pkg::OP_READ: begin
        ctrl.pos = item.index[6:0];
        ctrl.rd  = 1'b1;
        if (!in_rng) begin
          status    = ils_pkg::ST_RANGE;
          read_miss = 1'b1;
        end
      end
      ils_pkg::OP_HEAD: begin
        ctrl.pos = '0;
        if (full) begin
          status = ils_pkg::ST_FULL;
        end else begin
          ctrl.ins   = go;
          count_next = count + CW'(1);
        end
      end
      ils_pkg::OP_TAIL: begin
        ctrl.pos = ils_pkg::POS_W'(count);
        if (full) begin
          status = ils_pkg::ST_FULL;
        end else begin
          ctrl.ins   = go;
          count_next = count + CW'(1);
        end
      end
      ils_pkg::OP_AT: begin
        ctrl.pos = at8[6:0];
        if (at8 > cnt8) begin
          status = ils_pkg::ST_RANGE;
        end else if (full) begin
          status = ils_pkg::ST_FULL;
        end else begin
          ctrl.ins   = go;
          count_next = count + CW'(1);
        end
      end
      ils_pkg::OP_DEL: begin
        ctrl.pos = item.index[6:0];
        if (!in_rng) begin
          status = ils_pkg::ST_RANGE;
        end else begin
          ctrl.del   = go;
          count_next = count - CW'(1);
        end
      end
      default: begin
        ctrl.pos = '0;
      end
    endcase
  end

endmodule

// ----- design/indexed_list_store.sv -----
// Indexed list store: a chain of cells that shift together on insert and delete.
// An accepted transaction's result is registered in the output register in the next cycle.
// Throughput: one transaction per cycle unless the output stalls; insert/delete shifts cells from its position on.
// The output register frees itself in the cycle its result is taken, so no bubble appears.
// Reset clears the length and the output valid; cell contents are left as they are.
module indexed_list_store #(
  parameter int unsigned CAPACITY = ils_pkg::DEFAULT_CAPACITY
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  ils_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_stall,
  output ils_pkg::result_t result
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);

  logic [CW-1:0]      count;
  logic [CW-1:0]      count_dec;
  logic               fire;
  ils_pkg::ctrl_t     ctrl;
  ils_pkg::status_t   status;
  logic               read_miss;
  logic signed [31:0] data [CAPACITY];
  logic signed [31:0] taps [CAPACITY];
  logic signed [31:0] rd_bus;

  assign item_stall = result_valid && result_stall;
  assign fire       = item_valid && !item_stall;

  ils_decode #(
    .CAPACITY (CAPACITY),
    .CW       (CW)
  ) u_decode (
    .go         (fire),
    .item       (item),
    .count      (count),
    .ctrl       (ctrl),
    .status     (status),
    .read_miss  (read_miss),
    .count_next (count_dec)
  );

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [31:0] left_in;
    logic signed [31:0] right_in;

    if (i == 0) begin : g_first
      assign left_in = ctrl.value;
    end else begin : g_mid_l
      assign left_in = data[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_in = data[i];
    end else begin : g_mid_r
      assign right_in = data[i+1];
    end

    ils_cell #(
      .IDX (i)
    ) u_cell (
      .clk   (clk),
      .ctrl  (ctrl),
      .left  (left_in),
      .right (right_in),
      .data  (data[i]),
      .tap   (taps[i])
    );
  end

  always_comb begin
    rd_bus = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_bus = rd_bus | taps[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count        <= '0;
      result_valid <= 1'b0;
    end else begin
      if (fire) begin
        count        <= count_dec;
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      result.status <= status;
      result.length <= 5'(count_dec);
      if (read_miss) begin
        result.read_value <= -32'sd1;
      end else if (item.opcode == ils_pkg::OP_READ) begin
        result.read_value <= rd_bus;
      end else begin
        result.read_value <= '0;
      end
    end
  end

endmodule

// ----- tb/sv/indexed_list_store_test.sv -----
// Self-checking testbench for the indexed list store: directed and random list operations.
`timescale 1ns / 1ps

module indexed_list_store_test;

  localparam int STORE_CAP = ils_pkg::DEFAULT_CAPACITY;
  localparam logic [2:0] OP_UNUSED_FIRST = 3'd5;
  localparam logic [2:0] OP_UNUSED_LAST = 3'd7;
  localparam int MODE_FILL = 0;
  localparam int MODE_MIXED = 1;
  localparam int MODE_DRAIN = 2;
  localparam int ITEMS_PER_PHASE = 134;
  localparam int BLOCK_LEN = 16;
  localparam int LONG_HOLD = 60;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int MAX_REPORTS = 10;

  // Predicts the store's contents and length, and queues the result of each transaction.
  class list_scoreboard;
    logic signed [31:0] cells [STORE_CAP];
    int fill = 0;
    int errors = 0;
    ils_pkg::result_t expected_q [$];

    function logic [1:0] insert_at(int pos, logic signed [31:0] v);
      int k;
      if (fill >= STORE_CAP) return ils_pkg::ST_FULL;
      for (k = fill; k > pos; k--) cells[k] = cells[k - 1];
      cells[pos] = v;
      fill++;
      return ils_pkg::ST_DONE;
    endfunction

    function void note_item(ils_pkg::item_t it);
      ils_pkg::result_t r;
      int pos;
      int k;
      r.read_value = '0;
      r.status = ils_pkg::ST_DONE;
      pos = int'(it.index);
      case (it.opcode)
        ils_pkg::OP_READ: begin
          if (pos < 0 || pos >= fill) begin
            r.read_value = -1;
            r.status = ils_pkg::ST_RANGE;
          end else begin
            r.read_value = cells[pos];
          end
        end
        ils_pkg::OP_HEAD: r.status = insert_at(0, it.value);
        ils_pkg::OP_TAIL: r.status = insert_at(fill, it.value);
        ils_pkg::OP_AT: begin
          // A negative position is taken as the head; past the end is refused first.
          if (pos < 0) pos = 0;
          if (pos > fill) r.status = ils_pkg::ST_RANGE;
          else r.status = insert_at(pos, it.value);
        end
        ils_pkg::OP_DEL: begin
          if (pos < 0 || pos >= fill) begin
            r.status = ils_pkg::ST_RANGE;
          end else begin
            for (k = pos; k + 1 < fill; k++) cells[k] = cells[k + 1];
            fill--;
          end
        end
        default: ;
      endcase
      r.length = fill[4:0];
      expected_q.push_back(r);
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= MAX_REPORTS) $display("mismatch: %s", msg);
    endfunction

    function void check_result(ils_pkg::result_t got);
      ils_pkg::result_t want;
      if (expected_q.size() == 0) begin
        flag($sformatf("unexpected result value=%0d status=%0d length=%0d",
                       got.read_value, got.status, got.length));
        return;
      end
      want = expected_q.pop_front();
      if (got.read_value !== want.read_value || got.status !== want.status ||
          got.length !== want.length)
        flag($sformatf("value %0d/%0d status %0d/%0d length %0d/%0d (expected/actual)",
                       want.read_value, got.read_value, want.status, got.status,
                       want.length, got.length));
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  logic item_valid;
  logic item_stall;
  ils_pkg::item_t item;
  logic result_valid;
  logic result_stall;
  ils_pkg::result_t result;

  list_scoreboard sb = new();
  int send_idle_pct;
  int recv_stall_pct;
  int hold_req = 0;
  int hold_done = 0;
  int quiet_cycles = 0;

  indexed_list_store #(.CAPACITY(STORE_CAP)) dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item(item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: random stalls, and now and then a long hold so that the store backs up.
  initial begin
    result_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_done != hold_req) begin
        hold_done++;
        result_stall <= 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
      end else begin
        result_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // Every transaction on either side is seen here at the rising edge.
  always @(posedge clk) begin
    if (!rst && item_valid && !item_stall) sb.note_item(item);
    if (!rst && result_valid && !result_stall) sb.check_result(result);
    if ((item_valid && !item_stall) || (result_valid && !result_stall)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL indexed_list_store");
      $finish;
    end
  end

  // Called at a falling edge; returns at the falling edge after the transaction.
  task automatic send_item(input ils_pkg::item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item <= it;
    item_valid <= 1'b1;
    do @(posedge clk); while (item_stall);
    @(negedge clk);
  endtask

  task automatic send_op(input logic [2:0] op, input int idx, input logic signed [31:0] val);
    ils_pkg::item_t it;
    it.opcode = op;
    it.index = 8'(idx);
    it.value = val;
    send_item(it);
  endtask

  function automatic ils_pkg::item_t build_item(int mode);
    ils_pkg::item_t it;
    int r;
    int n;
    n = sb.fill;
    r = $urandom_range(99);
    if (r < 3) begin
      it.opcode = 3'($urandom_range(OP_UNUSED_LAST, OP_UNUSED_FIRST));
    end else begin
      r = $urandom_range(99);
      case (mode)
        MODE_FILL: begin
          if (r < 25) it.opcode = ils_pkg::OP_HEAD;
          else if (r < 50) it.opcode = ils_pkg::OP_TAIL;
          else if (r < 80) it.opcode = ils_pkg::OP_AT;
          else if (r < 95) it.opcode = ils_pkg::OP_READ;
          else it.opcode = ils_pkg::OP_DEL;
        end
        MODE_DRAIN: begin
          if (r < 75) it.opcode = ils_pkg::OP_DEL;
          else if (r < 90) it.opcode = ils_pkg::OP_READ;
          else if (r < 94) it.opcode = ils_pkg::OP_HEAD;
          else if (r < 97) it.opcode = ils_pkg::OP_TAIL;
          else it.opcode = ils_pkg::OP_AT;
        end
        default: begin
          if (r < 20) it.opcode = ils_pkg::OP_READ;
          else if (r < 35) it.opcode = ils_pkg::OP_HEAD;
          else if (r < 50) it.opcode = ils_pkg::OP_TAIL;
          else if (r < 70) it.opcode = ils_pkg::OP_AT;
          else it.opcode = ils_pkg::OP_DEL;
        end
      endcase
    end
    // Mostly a position that is in range, otherwise any position at all.
    if ($urandom_range(99) < 20 || (n == 0 && it.opcode != ils_pkg::OP_AT))
      it.index = 8'($urandom_range(255));
    else if (it.opcode == ils_pkg::OP_AT)
      it.index = 8'($urandom_range(n));
    else
      it.index = 8'($urandom_range(n - 1));
    r = $urandom_range(99);
    if (r < 3) it.value = 32'sh8000_0000;
    else if (r < 6) it.value = 32'sh7FFF_FFFF;
    else if (r < 8) it.value = '0;
    else if (r < 10) it.value = -1;
    else it.value = $urandom;
    return it;
  endfunction

  initial begin
    int p;
    int n;
    int mode;
    logic [2:0] op;
    rst = 1'b1;
    item_valid = 1'b0;
    item = '0;
    send_idle_pct = 17;
    recv_stall_pct = 72;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Operations on an empty store, then the clamped and refused positions.
    send_op(ils_pkg::OP_READ, 0, 0);
    send_op(ils_pkg::OP_DEL, 0, 0);
    send_op(ils_pkg::OP_AT, 1, 32'sh1234_5678);
    send_op(ils_pkg::OP_AT, -128, 32'sh7FFF_FFFF);
    send_op(ils_pkg::OP_HEAD, 0, 32'sh8000_0000);
    send_op(ils_pkg::OP_TAIL, 0, 0);
    send_op(ils_pkg::OP_AT, 1, -1);
    send_op(ils_pkg::OP_AT, 127, 32'sh0F0F_0F0F);
    send_op(ils_pkg::OP_READ, 0, 0);
    send_op(ils_pkg::OP_READ, 1, 0);
    send_op(ils_pkg::OP_READ, 2, 0);
    send_op(ils_pkg::OP_READ, 3, 0);
    send_op(ils_pkg::OP_READ, -1, 0);
    send_op(ils_pkg::OP_READ, -128, 0);
    send_op(ils_pkg::OP_READ, 127, 0);
    send_op(ils_pkg::OP_DEL, 127, 0);
    send_op(ils_pkg::OP_DEL, -128, 0);
    send_op(ils_pkg::OP_DEL, 1, 0);
    send_op(ils_pkg::OP_READ, 1, 0);
    for (op = OP_UNUSED_FIRST; op != OP_UNUSED_LAST + 3'd1; op++)
      send_op(op, 0, 32'sh5A5A_5A5A);
    send_op(ils_pkg::OP_TAIL, 0, 32'sh5555_5555);
    send_op(ils_pkg::OP_AT, 2, 32'shAAAA_AAAA);

    // Three idling patterns; the store is filled to capacity and drained in blocks.
    for (p = 0; p < 3; p++) begin
      send_idle_pct = (p == 0) ? 17 : ((p == 1) ? 72 : 0);
      recv_stall_pct = (p == 0) ? 72 : ((p == 1) ? 17 : 0);
      if (p > 0) hold_req++;
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        mode = ((n / BLOCK_LEN) % 4 < 2) ? MODE_FILL :
               (((n / BLOCK_LEN) % 4 == 2) ? MODE_MIXED : MODE_DRAIN);
        send_item(build_item(mode));
      end
    end
    item_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS indexed_list_store");
    end else begin
      $display("FAIL indexed_list_store");
    end
    $finish;
  end

endmodule
